// File: sv/ppc_pkg.sv
// Shared types and constants for the point polygon contact block.
`timescale 1ns / 1ps
package ppc_pkg;

  localparam int PPC_MAX_SIDES = 16;

  localparam int COORD_W  = 32;
  localparam int SIDES_W  = 5;
  localparam int RADIUS_W = 31;
  localparam int SLOT_W   = 4;
  localparam int NRM_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 72;

  localparam int OP_W   = 35;
  localparam int PROD_W = 2 * OP_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RAD_W  = 68;
  localparam int ROOT_W = RAD_W / 2;
  localparam int QW     = 15;
  localparam int NUM_W  = 48;
  localparam int FRAC_SHIFT = 14;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDES  = 1'b0,
    REG_RADIUS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  typedef struct packed {
    logic    en;
    mac_op_t op;
  } mac_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RAD,
    S_WALK,
    S_P0,
    S_P1,
    S_E1,
    S_E2,
    S_NRM,
    S_ROOT,
    S_DIVX,
    S_DIVY,
    S_DEP,
    S_DONE
  } state_t;

endpackage

// File: sv/point_polygon_contact.sv
// Top level: point in convex polygon test with inward normal and depth.
// A load item is written to the vertex store as it is accepted. A query runs the radius test,
// walks the vertices; on a hit it reads the vertex pair, runs the edge tests, the squared sum
// and the square root unit and, for a nonzero root, the divider for each normal component and
// the depth step; it hands the result to the output register before the next item is accepted.
// Reset (rst_n low, synchronous) gives 4 sides and radius 0; vertices are not cleared.
`timescale 1ns / 1ps
module point_polygon_contact #(
  parameter int MAX_SIDES = ppc_pkg::PPC_MAX_SIDES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // vertex_slot[3:0], coord_x[35:4], coord_y[67:36], center_x[99:68],
  // center_y[131:100], zero pad
  input  logic [ppc_pkg::IN_DATA_W-1:0]       in_tdata,
  // mode[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // is_hit[0], normal_x[16:1], normal_y[32:17], depth[64:33], zero pad
  output logic [ppc_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ppc_pkg::*;

  localparam int AW = $clog2(MAX_SIDES);
  localparam int NW = $clog2(MAX_SIDES + 1);
  localparam logic [2:0] PH_A    = 3'd1;
  localparam logic [2:0] PH_B    = 3'd2;
  localparam logic [2:0] PH_C    = 3'd3;
  localparam logic [2:0] PH_READ = 3'd5;
  localparam logic signed [COORD_W-1:0] D32_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] D32_MIN = 32'sh8000_0000;
  localparam logic signed [ACC_W-1:0]   HALF_LSB = ACC_W'(1) <<< (FRAC_SHIFT - 1);

  state_t state_r, state_nxt;
  logic [2:0] ph_r, ph_nxt;

  logic [SIDES_W-1:0]  sides_r;
  logic [RADIUS_W-1:0] radius_r;

  logic signed [COORD_W:0]   sx_r, sy_r;
  logic [NW-1:0]             n_r;
  logic [AW-1:0]             addr_r;
  logic [AW-1:0]             nxt_r;
  logic                      c0_pos_r, prev_neg_r;
  logic signed [COORD_W:0]   np0x_r, np0y_r;
  logic signed [COORD_W+1:0] ux_r, uy_r;
  logic signed [COORD_W:0]   dx_r, dy_r, smx_r, smy_r;
  logic [ROOT_W-1:0]         m_r;
  logic                      hit_r;
  logic signed [NRM_W-1:0]   nrmx_r, nrmy_r;
  logic signed [COORD_W-1:0] depth_r;
  logic                      out_tvalid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  logic [SLOT_W-1:0]         in_slot;
  logic signed [COORD_W-1:0] in_cx, in_cy, in_ctr_x, in_ctr_y;
  logic                      in_acc;
  logic [NW-1:0]             n_eff;

  logic                      we;
  logic signed [COORD_W-1:0] rd_x, rd_y;

  mac_cmd_t                  mcmd;
  logic signed [OP_W-1:0]    opa, opb;
  logic signed [ACC_W-1:0]   acc;
  logic                      acc_pos, acc_neg;

  logic                      root_start, root_done;
  logic [ROOT_W-1:0]         root;
  logic                      div_start, div_done;
  logic [NUM_W-1:0]          div_num;
  logic [QW-1:0]             div_quo;
  logic [COORD_W:0]          sm_mag;
  logic signed [COORD_W:0]   sm_sel;
  logic signed [NRM_W-1:0]   nrm_q;

  logic                      last_k, pair_hit, wrap_hit;
  logic signed [ACC_W-1:0]   dep_t;
  logic signed [ACC_W-1:0]   dep_sh;
  logic signed [COORD_W-1:0] dep_sat;
  logic                      load_out;

  assign in_slot  = in_tdata[3:0];
  assign in_cx    = $signed(in_tdata[35:4]);
  assign in_cy    = $signed(in_tdata[67:36]);
  assign in_ctr_x = $signed(in_tdata[99:68]);
  assign in_ctr_y = $signed(in_tdata[131:100]);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign we = in_acc && (in_tuser == MODE_LOAD) && (32'(in_slot) < 32'(MAX_SIDES));

  assign n_eff = (32'(sides_r) > 32'(MAX_SIDES)) ? NW'(MAX_SIDES) : NW'(sides_r);

  assign acc_neg = acc[ACC_W-1];
  assign acc_pos = !acc[ACC_W-1] && (acc != '0);

  assign last_k   = ((NW'(addr_r) + NW'(1)) == n_r);
  assign pair_hit = (addr_r != '0) && prev_neg_r && acc_pos;
  assign wrap_hit = last_k && acc_neg && ((addr_r == '0) ? 1'b0 : c0_pos_r);

  assign sm_sel  = (state_r == S_DIVX) ? smx_r : smy_r;
  assign sm_mag  = sm_sel[COORD_W] ? (COORD_W+1)'(-sm_sel) : (COORD_W+1)'(sm_sel);
  assign div_num = (NUM_W'(sm_mag) << FRAC_SHIFT) + NUM_W'(m_r >> 1);
  assign nrm_q   = sm_sel[COORD_W] ? $signed(NRM_W'(div_quo)) : -$signed(NRM_W'(div_quo));

  assign dep_t  = acc + HALF_LSB;
  assign dep_sh = dep_t >>> FRAC_SHIFT;
  assign dep_sat = (dep_sh > ACC_W'(D32_MAX)) ? D32_MAX :
                   (dep_sh < ACC_W'(D32_MIN)) ? D32_MIN : COORD_W'(dep_sh);

  assign load_out = (state_r == S_DONE) && (!out_tvalid_r || out_tready);

  ppc_vstore #(.DEPTH(MAX_SIDES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(in_slot)),
    .wx    (in_cx),
    .wy    (in_cy),
    .raddr (addr_r),
    .rx    (rd_x),
    .ry    (rd_y)
  );

  ppc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (mcmd),
    .op_a  (opa),
    .op_b  (opb),
    .acc   (acc)
  );

  ppc_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (acc[RAD_W-1:0]),
    .done     (root_done),
    .root     (root)
  );

  ppc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (m_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ph_r         <= '0;
      sides_r      <= SIDES_W'(4);
      radius_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SIDES:  sides_r  <= cfg_data[SIDES_W-1:0];
          REG_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
          default:    sides_r  <= sides_r;
        endcase
      end
      if (load_out) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == MODE_QUERY)) begin
      sx_r    <= (COORD_W+1)'(in_cx) - (COORD_W+1)'(in_ctr_x);
      sy_r    <= (COORD_W+1)'(in_cy) - (COORD_W+1)'(in_ctr_y);
      n_r     <= n_eff;
      hit_r   <= 1'b0;
      nrmx_r  <= '0;
      nrmy_r  <= '0;
      depth_r <= '0;
    end
    if (state_r == S_RAD && ph_r == PH_READ) begin
      addr_r <= '0;
    end
    if (state_r == S_WALK && ph_r == PH_READ) begin
      prev_neg_r <= acc_neg;
      if (addr_r == '0) begin
        c0_pos_r <= acc_pos;
      end
      if (pair_hit) begin
        addr_r <= addr_r - 1'b1;
        nxt_r  <= addr_r;
      end else if (wrap_hit) begin
        nxt_r <= '0;
      end else if (!last_k) begin
        addr_r <= addr_r + 1'b1;
      end
    end
    if (state_r == S_P0 && ph_r == PH_A) begin
      np0x_r <= -((COORD_W+1)'(rd_x));
      np0y_r <= -((COORD_W+1)'(rd_y));
      addr_r <= nxt_r;
    end
    if (state_r == S_P1 && ph_r == PH_A) begin
      ux_r  <= (COORD_W+2)'(sx_r) + (COORD_W+2)'(np0x_r);
      uy_r  <= (COORD_W+2)'(sy_r) + (COORD_W+2)'(np0y_r);
      dx_r  <= (COORD_W+1)'(rd_x) + np0x_r;
      dy_r  <= (COORD_W+1)'(rd_y) + np0y_r;
      smx_r <= (COORD_W+1)'(rd_x) - np0x_r;
      smy_r <= (COORD_W+1)'(rd_y) - np0y_r;
    end
    if (state_r == S_E2 && ph_r == PH_READ) begin
      hit_r <= acc_neg;
    end
    if (state_r == S_ROOT && root_done) begin
      m_r <= root;
    end
    if (state_r == S_DIVX && div_done) begin
      nrmx_r <= nrm_q;
    end
    if (state_r == S_DIVY && div_done) begin
      nrmy_r <= nrm_q;
    end
    if (state_r == S_DEP && ph_r == PH_READ) begin
      depth_r <= dep_sat;
    end
    if (load_out) begin
      out_data_r <= {7'b0, depth_r, nrmy_r, nrmx_r, hit_r};
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ph_nxt     = ph_r;
    mcmd       = '0;
    opa        = '0;
    opb        = '0;
    root_start = 1'b0;
    div_start  = 1'b0;
    if (ph_r != PH_READ) begin
      ph_nxt = ph_r + 3'd1;
    end
    unique case (state_r) inside
      S_IDLE: begin
        ph_nxt = '0;
        if (in_acc && (in_tuser == MODE_QUERY)) begin
          state_nxt = S_RAD;
        end
      end
      S_RAD: begin
        if (ph_r == PH_A) begin
          mcmd = '{en: 1'b1, op: MAC_LOAD};
          opa  = OP_W'(sx_r);
          opb  = OP_W'(sx_r);
        end else if (ph_r == PH_B) begin
          mcmd = '{en: 1'b1, op: MAC_ADD};
          opa  = OP_W'(sy_r);
          opb  = OP_W'(sy_r);
        end else if (ph_r == PH_C) begin
          mcmd = '{en: 1'b1, op: MAC_SUB};
          opa  = $signed(OP_W'(radius_r));
          opb  = $signed(OP_W'(radius_r));
        end else if (ph_r == PH_READ) begin
          ph_nxt    = '0;
          state_nxt = (acc_pos || n_r == '0) ? S_DONE : S_WALK;
        end
      end
      S_WALK: begin
        if (ph_r == PH_A) begin
          mcmd = '{en: 1'b1, op: MAC_LOAD};
          opa  = OP_W'(sx_r);
          opb  = OP_W'(rd_y);
        end else if (ph_r == PH_B) begin
          mcmd = '{en: 1'b1, op: MAC_SUB};
          opa  = OP_W'(sy_r);
          opb  = OP_W'(rd_x);
        end else if (ph_r == PH_READ) begin
          ph_nxt = '0;
          if (pair_hit || wrap_hit) begin
            state_nxt = S_P0;
          end else if (last_k) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_P0: begin
        if (ph_r == PH_A) begin
          ph_nxt    = '0;
          state_nxt = S_P1;
        end
      end
      S_P1: begin
        if (ph_r == PH_A) begin
          ph_nxt    = '0;
          state_nxt = S_E1;
        end
      end
      S_E1: begin
        if (ph_r == PH_A) begin
          mcmd = '{en: 1'b1, op: MAC_LOAD};
          opa  = OP_W'(ux_r);
          opb  = OP_W'(np0y_r);
        end else if (ph_r == PH_B) begin
          mcmd = '{en: 1'b1, op: MAC_SUB};
          opa  = OP_W'(uy_r);
          opb  = OP_W'(np0x_r);
        end else if (ph_r == PH_READ) begin
          ph_nxt    = '0;
          state_nxt = acc_pos ? S_E2 : S_DONE;
        end
      end
      S_E2: begin
        if (ph_r == PH_A) begin
          mcmd = '{en: 1'b1, op: MAC_LOAD};
          opa  = OP_W'(ux_r);
          opb  = OP_W'(dy_r);
        end else if (ph_r == PH_B) begin
          mcmd = '{en: 1'b1, op: MAC_SUB};
          opa  = OP_W'(uy_r);
          opb  = OP_W'(dx_r);
        end else if (ph_r == PH_READ) begin
          ph_nxt    = '0;
          state_nxt = acc_neg ? S_NRM : S_DONE;
        end
      end
      S_NRM: begin
        if (ph_r == PH_A) begin
          mcmd = '{en: 1'b1, op: MAC_LOAD};
          opa  = OP_W'(smx_r);
          opb  = OP_W'(smx_r);
        end else if (ph_r == PH_B) begin
          mcmd = '{en: 1'b1, op: MAC_ADD};
          opa  = OP_W'(smy_r);
          opb  = OP_W'(smy_r);
        end else if (ph_r == PH_READ) begin
          ph_nxt     = '0;
          root_start = 1'b1;
          state_nxt  = S_ROOT;
        end
      end
      S_ROOT: begin
        ph_nxt = '0;
        if (root_done) begin
          // A zero-length vertex sum leaves the normal and depth at zero.
          state_nxt = (root == '0) ? S_DONE : S_DIVX;
        end
      end
      S_DIVX, S_DIVY: begin
        ph_nxt = PH_A;
        if (ph_r == '0) begin
          div_start = 1'b1;
        end else if (div_done) begin
          ph_nxt    = '0;
          state_nxt = (state_r == S_DIVX) ? S_DIVY : S_DEP;
        end
      end
      S_DEP: begin
        if (ph_r == PH_A) begin
          mcmd = '{en: 1'b1, op: MAC_LOAD};
          opa  = OP_W'(ux_r);
          opb  = OP_W'(nrmx_r);
        end else if (ph_r == PH_B) begin
          mcmd = '{en: 1'b1, op: MAC_ADD};
          opa  = OP_W'(uy_r);
          opb  = OP_W'(nrmy_r);
        end else if (ph_r == PH_READ) begin
          ph_nxt    = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ph_nxt = '0;
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        ph_nxt    = '0;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[64:1] == '0))
    else $error("miss result carries a nonzero normal or depth");

  a_nrm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[16:1]) >= -16'sd16384 &&
                    $signed(out_tdata[16:1]) <= 16'sd16384 &&
                    $signed(out_tdata[32:17]) >= -16'sd16384 &&
                    $signed(out_tdata[32:17]) <= 16'sd16384))
    else $error("normal component outside unit range");

  a_root_state: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == S_ROOT))
    else $error("square root finished outside its wait state");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVX || state_r == S_DIVY))
    else $error("divider finished outside its wait states");

endmodule

// File: sv/ppc_vstore.sv
// Vertex offset memory with one write port and one registered read port.
`timescale 1ns / 1ps
module ppc_vstore #(
  parameter int DEPTH = ppc_pkg::PPC_MAX_SIDES,
  parameter int AW    = $clog2(ppc_pkg::PPC_MAX_SIDES)
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [AW-1:0]                       waddr,
  input  logic signed [ppc_pkg::COORD_W-1:0]  wx,
  input  logic signed [ppc_pkg::COORD_W-1:0]  wy,
  input  logic [AW-1:0]                       raddr,
  output logic signed [ppc_pkg::COORD_W-1:0]  rx,
  output logic signed [ppc_pkg::COORD_W-1:0]  ry
);
  import ppc_pkg::*;

  logic [2*COORD_W-1:0] mem [DEPTH];
  logic [2*COORD_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wy, wx};
    end
    rd_r <= mem[raddr];
  end

  assign rx = $signed(rd_r[COORD_W-1:0]);
  assign ry = $signed(rd_r[2*COORD_W-1:COORD_W]);

endmodule

// File: sv/ppc_mac.sv
// Shared signed multiplier with a registered product and an accumulator.
`timescale 1ns / 1ps
module ppc_mac (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ppc_pkg::mac_cmd_t                  cmd,
  input  logic signed [ppc_pkg::OP_W-1:0]    op_a,
  input  logic signed [ppc_pkg::OP_W-1:0]    op_b,
  output logic signed [ppc_pkg::ACC_W-1:0]   acc
);
  import ppc_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  mac_cmd_t                 cmd_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    acc_r  <= acc_nxt;
    if (!rst_n) begin
      cmd_r <= '0;
    end else begin
      cmd_r <= cmd;
    end
  end

  always_comb begin
    prod_ext = ACC_W'(prod_r);
    acc_nxt  = acc_r;
    if (cmd_r.en) begin
      case (cmd_r.op)
        MAC_LOAD: acc_nxt = prod_ext;
        MAC_ADD:  acc_nxt = acc_r + prod_ext;
        MAC_SUB:  acc_nxt = acc_r - prod_ext;
        default:  acc_nxt = acc_r;
      endcase
    end
  end

  assign acc = acc_r;

endmodule

// File: sv/ppc_root.sv
// Bit-serial integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module ppc_root (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ppc_pkg::RAD_W-1:0]     radicand,
  output logic                          done,
  output logic [ppc_pkg::ROOT_W-1:0]    root
);
  import ppc_pkg::*;

  logic [RAD_W-1:0] op_r;
  logic [RAD_W-1:0] res_r;
  logic [RAD_W-1:0] bit_r;
  logic             busy_r;
  logic             done_r;
  logic [RAD_W:0]   trial;
  logic             ge;

  assign trial = {1'b0, res_r} + {1'b0, bit_r};
  assign ge    = ({1'b0, op_r} >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        op_r   <= radicand;
        res_r  <= '0;
        bit_r  <= RAD_W'(1) << (RAD_W - 2);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ge) begin
          op_r  <= op_r - trial[RAD_W-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        // The last step is the one whose bit reaches the bottom.
        if ((bit_r >> 2) == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

// File: sv/ppc_div.sv
// Restoring divider for the normal components, one quotient bit per cycle.
`timescale 1ns / 1ps
module ppc_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ppc_pkg::NUM_W-1:0]     num,
  input  logic [ppc_pkg::ROOT_W-1:0]    den,
  output logic                          done,
  output logic [ppc_pkg::QW-1:0]        quo
);
  import ppc_pkg::*;

  localparam int CNT_W = $clog2(QW + 1);

  logic [ROOT_W-1:0] rem_r;
  logic [QW-1:0]     low_r;
  logic [QW-1:0]     quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [ROOT_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, low_r[QW-1]};
  assign ge    = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // The quotient stays below 2^QW, so the top bits are already below den.
        rem_r  <= ROOT_W'(num[NUM_W-1:QW]);
        low_r  <= num[QW-1:0];
        quo_r  <= '0;
        cnt_r  <= CNT_W'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? ROOT_W'(trial - {1'b0, den}) : ROOT_W'(trial);
        low_r <= low_r << 1;
        quo_r <= {quo_r[QW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: tb/tb.sv
// Testbench for the point polygon contact block: random polygons, queries and a result checker.
`timescale 1ns / 1ps
module tb;
  import ppc_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic               hit;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [31:0] depth;
  } contact_t;

  class contact_scoreboard;
    int               sides;
    longint unsigned  radius;
    longint           vx[PPC_MAX_SIDES];
    longint           vy[PPC_MAX_SIDES];
    contact_t         expected_q[$];
    int               fails;

    function new();
      sides  = 4;
      radius = 0;
      fails  = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_SIDES) sides = d[SIDES_W-1:0];
      else radius = d[RADIUS_W-1:0];
    endfunction

    function int cross_sgn(longint ax, longint ay, longint bx, longint by);
      wide_t p;
      p = wide_t'(ax) * wide_t'(by) - wide_t'(ay) * wide_t'(bx);
      return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
    endfunction

    function longint unsigned floor_root(wide_t v);
      longint unsigned r, c;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (wide_t'(c) * wide_t'(c) <= v) r = c;
      end
      return r;
    endfunction

    // Rounds half away from zero, then negates to point inward.
    function longint unit_comp(longint s, longint unsigned m);
      longint unsigned mag, q;
      mag = (s < 0) ? longint'(-s) : longint'(s);
      q = (mag * 16384 + m / 2) / m;
      return (s < 0) ? longint'(q) : -longint'(q);
    endfunction

    function void note_input(logic mode, logic [3:0] slot, logic signed [31:0] x,
                             logic signed [31:0] y, logic signed [31:0] cx,
                             logic signed [31:0] cy);
      longint sx, sy, p0x, p0y, p1x, p1y, ux, uy, smx, smy, acc, t, d;
      int n, j, found, nxt;
      bit have;
      longint unsigned m;
      contact_t e;
      if (mode == MODE_LOAD) begin
        vx[slot] = x;
        vy[slot] = y;
        return;
      end
      e = '{hit: 0, nx: 0, ny: 0, depth: 0};
      sx = longint'(x) - longint'(cx);
      sy = longint'(y) - longint'(cy);
      n = (sides > PPC_MAX_SIDES) ? PPC_MAX_SIDES : sides;
      have = 0;
      found = 0;
      nxt = 0;
      if (wide_t'(radius) * wide_t'(radius) >=
          wide_t'(sx) * wide_t'(sx) + wide_t'(sy) * wide_t'(sy)) begin
        for (int i = 0; i < n && !have; i++) begin
          j = (i + 1 == n) ? 0 : i + 1;
          if (cross_sgn(sx, sy, vx[i], vy[i]) < 0 && cross_sgn(sx, sy, vx[j], vy[j]) > 0) begin
            have = 1;
            found = i;
            nxt = j;
          end
        end
      end
      if (have) begin
        p0x = vx[found]; p0y = vy[found];
        p1x = vx[nxt];   p1y = vy[nxt];
        ux = sx - p0x;
        uy = sy - p0y;
        if (cross_sgn(ux, uy, -p0x, -p0y) > 0 &&
            cross_sgn(ux, uy, p1x - p0x, p1y - p0y) < 0) begin
          smx = p0x + p1x;
          smy = p0y + p1y;
          m = floor_root(wide_t'(smx) * wide_t'(smx) + wide_t'(smy) * wide_t'(smy));
          e.hit = 1;
          if (m != 0) begin
            e.nx = unit_comp(smx, m);
            e.ny = unit_comp(smy, m);
            acc = ux * longint'(e.nx) + uy * longint'(e.ny);
            t = acc + 8192;
            d = t >>> FRAC_SHIFT;
            if (d > 64'sd2147483647) d = 64'sd2147483647;
            if (d < -64'sd2147483648) d = -64'sd2147483648;
            e.depth = d;
          end
        end
      end
      expected_q = {expected_q, e};
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      contact_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        fails++;
        return;
      end
      e = expected_q.pop_front();
      if (d[0] !== e.hit) begin
        $display("%0t: is_hit expected %0d actual %0d", $time, e.hit, d[0]);
        fails++;
      end
      if (d[16:1] !== e.nx) begin
        $display("%0t: normal_x expected %0d actual %0d", $time, e.nx, $signed(d[16:1]));
        fails++;
      end
      if (d[32:17] !== e.ny) begin
        $display("%0t: normal_y expected %0d actual %0d", $time, e.ny, $signed(d[32:17]));
        fails++;
      end
      if (d[64:33] !== e.depth) begin
        $display("%0t: depth expected %0d actual %0d", $time, e.depth, $signed(d[64:33]));
        fails++;
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  contact_scoreboard sb = new();
  bit  steady = 0;     // no idling on either side while set
  bit  hold_req = 0;   // asks the receiver for one long hold-off
  int  quiet_cycles = 0;
  real pi = 3.14159265358979;

  point_polygon_contact dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    bit moved;
    moved = 0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_input(in_tuser, in_tdata[3:0], in_tdata[35:4], in_tdata[67:36],
                      in_tdata[99:68], in_tdata[131:100]);
        moved = 1;
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        moved = 1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
        moved = 1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        @(negedge clk) out_tready <= 0;
        repeat (700) @(negedge clk);
      end
      g = pick_gap();
      if (g > 0) begin
        @(negedge clk) out_tready <= 0;
        repeat (g - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  task automatic send(logic mode, logic [3:0] slot, logic [31:0] x, logic [31:0] y,
                      logic [31:0] cx, logic [31:0] cy);
    int g;
    g = pick_gap();
    if (g > 0) begin
      @(negedge clk) in_tvalid <= 0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, cy, cx, y, x, slot};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_vertex(int slot, logic [31:0] x, logic [31:0] y);
    send(MODE_LOAD, 4'(slot), x, y, $urandom, $urandom);
  endtask

  task automatic query(logic [31:0] x, logic [31:0] y, logic [31:0] cx, logic [31:0] cy);
    send(MODE_QUERY, 4'($urandom_range(0, 15)), x, y, cx, cy);
  endtask

  // Waits for every outstanding result, then lets a trailing load settle.
  task automatic drain();
    @(negedge clk) in_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 0;
  endtask

  // Loads a roughly regular polygon of n vertices and size rad; the jitter can make it slightly non-convex.
  task automatic load_polygon(int n, real rad);
    real a, r;
    for (int k = 0; k < n; k++) begin
      a = 2.0 * pi * k / n + (($urandom_range(0, 1000) / 1000.0) - 0.5) * pi / (2.0 * n);
      r = rad * (0.85 + $urandom_range(0, 150) / 1000.0);
      load_vertex(k, $rtoi(r * $cos(a)), $rtoi(r * $sin(a)));
    end
  endtask

  initial begin
    int n, items, pick;
    real rad;
    logic [31:0] cx, cy, ox, oy;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1;

    // Directed: a square of size 4096, then extreme vertices in the unused slots.
    load_vertex(0, 32'd4096, 0);
    load_vertex(1, 0, 32'd4096);
    load_vertex(2, -32'sd4096, 0);
    load_vertex(3, 0, -32'sd4096);
    for (int k = 4; k < PPC_MAX_SIDES; k++)
      load_vertex(k, (k % 2) ? 32'h7fffffff : 32'h80000000,
                  (k % 3) ? 32'h80000000 : 32'h7fffffff);
    query(32'd100, 32'd50, 0, 0);            // radius 0 gives a miss
    query(0, 0, 0, 0);
    drain();
    write_reg(REG_RADIUS, 32'h7fffffff);
    query(32'd1100, 32'd600, 32'd1000, 32'd500);
    query(-32'sd1000, 32'd1000, 0, 0);
    query(32'd5000, 32'd5000, 0, 0);
    query(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
    query(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    query(32'd4095, 0, 0, 0);
    drain();
    write_reg(REG_SIDES, 0);
    query(32'd10, 32'd10, 0, 0);
    drain();
    write_reg(REG_SIDES, 2);
    query(32'd10, -32'sd10, 0, 0);
    drain();
    write_reg(REG_SIDES, 31);
    query(32'h12345678, 32'hedcba987, 0, 0);
    drain();

    // Random phases: each one a fresh polygon, settings and mix of items.
    for (int ph = 0; ph < 11; ph++) begin
      pick = $urandom_range(0, 9);
      n = (ph == 0) ? 3 : (ph == 1) ? 16 : (pick == 0) ? 17 + $urandom_range(0, 14) :
          $urandom_range(3, 16);
      rad = (ph == 2) ? 268435456.0 : 256.0 * (1 << $urandom_range(0, 14));
      steady = (ph % 4 == 3);
      load_polygon((n > 16) ? 16 : n, rad);
      drain();
      write_reg(REG_SIDES, n);
      write_reg(REG_RADIUS, (ph == 5) ? 0 : (ph == 6) ? 32'h7fffffff :
                $rtoi(rad * (0.9 + $urandom_range(0, 300) / 1000.0)));
      if (ph == 4) hold_req = 1;
      items = 0;
      while (items < 52) begin
        pick = $urandom_range(0, 99);
        cx = $urandom_range(0, 32'h3fffffff) - 32'h20000000;
        cy = $urandom_range(0, 32'h3fffffff) - 32'h20000000;
        ox = $rtoi(rad * (($urandom_range(0, 2400) / 1000.0) - 1.2));
        oy = $rtoi(rad * (($urandom_range(0, 2400) / 1000.0) - 1.2));
        if (pick < 85) query(cx + ox, cy + oy, cx, cy);
        else if (pick < 93) query($urandom, $urandom, $urandom, $urandom);
        else load_vertex($urandom_range(0, 15), ox, oy);
        items++;
      end
      drain();
    end

    if (sb.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
